// ----- sv/crc_protected_block_framer_top_macros.svh -----
// assertion helpers used by the framer back end
`ifndef CRC_PROTECTED_BLOCK_FRAMER_TOP_MACROS_SVH
`define CRC_PROTECTED_BLOCK_FRAMER_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define CPBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define CPBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cpbf_pkg.sv -----
package cpbf_pkg;

    localparam int BLOCK_DATA_BYTES = 32;
    localparam int RECORD_BYTES     = BLOCK_DATA_BYTES + 2;
    localparam int POS_W            = $clog2(BLOCK_DATA_BYTES);
    localparam int QUEUE_DEPTH      = 2;
    localparam int Q_PTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W          = $clog2(QUEUE_DEPTH + 1);

    // position of the last data byte in a record
    localparam logic [POS_W-1:0] POS_END = POS_W'(BLOCK_DATA_BYTES - 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [7:0]  PAD_BYTE = 8'hFF;

    // one classified input transaction
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        first;
        logic [31:0] offset;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    // crc-16, msb first, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/cpbf_front.sv -----
module cpbf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    input  logic [25:0]           i_start_block,
    input  cpbf_pkg::t_q_flags    i_q_flags,
    output logic                  o_push,
    output cpbf_pkg::t_item       o_item
);

    logic r_active;
    logic n_active;

    assign o_in_ready = !i_q_flags.full;
    assign o_push     = i_in_valid && o_in_ready;

    // first byte of a write carries the record offset of its start block
    always_comb begin
        o_item.data   = i_data_byte;
        o_item.last   = i_last_byte;
        o_item.first  = !r_active;
        o_item.offset = 32'(32'(i_start_block) * 32'(cpbf_pkg::RECORD_BYTES));
    end

    always_comb begin
        n_active = r_active;
        if (o_push) begin
            n_active = !i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

endmodule

// ----- sv/cpbf_queue.sv -----
module cpbf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cpbf_pkg::t_item    i_item,
    input  logic               i_pop,
    output cpbf_pkg::t_item    o_item,
    output cpbf_pkg::t_q_flags o_flags
);

    cpbf_pkg::t_item                    r_mem [cpbf_pkg::QUEUE_DEPTH];
    logic [cpbf_pkg::Q_PTR_W-1:0]       r_wr_ptr;
    logic [cpbf_pkg::Q_PTR_W-1:0]       r_rd_ptr;
    logic [cpbf_pkg::Q_CNT_W-1:0]       r_count;
    logic [cpbf_pkg::Q_PTR_W-1:0]       n_wr_ptr;
    logic [cpbf_pkg::Q_PTR_W-1:0]       n_rd_ptr;
    logic [cpbf_pkg::Q_CNT_W-1:0]       n_count;

    assign o_flags.full  = (r_count == cpbf_pkg::Q_CNT_W'(cpbf_pkg::QUEUE_DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign o_item        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == cpbf_pkg::Q_PTR_W'(cpbf_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : cpbf_pkg::Q_PTR_W'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == cpbf_pkg::Q_PTR_W'(cpbf_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : cpbf_pkg::Q_PTR_W'(r_rd_ptr + 1'b1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = cpbf_pkg::Q_CNT_W'(r_count + 1'b1);
            2'b01:   n_count = cpbf_pkg::Q_CNT_W'(r_count - 1'b1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- sv/cpbf_back.sv -----
`include "crc_protected_block_framer_top_macros.svh"

module cpbf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_flash_base,
    input  cpbf_pkg::t_item    i_item,
    input  cpbf_pkg::t_q_flags i_q_flags,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_flash_byte,
    output logic [31:0]        o_flash_addr,
    output logic               o_write_done
);

    typedef enum logic [3:0] {
        S_DATA   = 4'b0001,
        S_PAD    = 4'b0010,
        S_CRC_HI = 4'b0100,
        S_CRC_LO = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    logic [cpbf_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [15:0]                  r_crc, n_crc;
    logic [31:0]                  r_addr, n_addr;
    logic                         r_last, n_last;
    logic                         r_out_valid;
    logic [7:0]                   r_out_byte;
    logic [31:0]                  r_out_addr;
    logic                         r_out_done;

    logic                         adv;
    logic                         load;
    logic [7:0]                   load_byte;
    logic [31:0]                  load_addr;
    logic                         load_done;
    logic [31:0]                  cur_addr;
    logic [15:0]                  cur_crc;
    logic [cpbf_pkg::POS_W-1:0]   cur_pos;

    // output register frees up when empty or being taken
    assign adv = !r_out_valid || i_out_ready;

    assign cur_addr = i_item.first ? (i_flash_base + i_item.offset) : r_addr;
    assign cur_crc  = i_item.first ? cpbf_pkg::CRC_INIT : r_crc;
    assign cur_pos  = i_item.first ? '0 : r_pos;

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_addr    = r_addr;
        n_last    = r_last;
        o_pop     = 1'b0;
        load      = 1'b0;
        load_byte = i_item.data;
        load_addr = r_addr;
        load_done = 1'b0;
        unique case (r_state)
            S_DATA: begin
                if (adv && !i_q_flags.empty) begin
                    o_pop     = 1'b1;
                    load      = 1'b1;
                    load_byte = i_item.data;
                    load_addr = cur_addr;
                    n_crc     = cpbf_pkg::crc_feed(cur_crc, i_item.data);
                    n_addr    = cur_addr + 32'd1;
                    n_last    = i_item.last;
                    n_pos     = cpbf_pkg::POS_W'(cur_pos + 1'b1);
                    if (cur_pos == cpbf_pkg::POS_END) begin
                        n_state = S_CRC_HI;
                    end else if (i_item.last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (adv) begin
                    load      = 1'b1;
                    load_byte = cpbf_pkg::PAD_BYTE;
                    n_crc     = cpbf_pkg::crc_feed(r_crc, cpbf_pkg::PAD_BYTE);
                    n_addr    = r_addr + 32'd1;
                    n_pos     = cpbf_pkg::POS_W'(r_pos + 1'b1);
                    if (r_pos == cpbf_pkg::POS_END) begin
                        n_state = S_CRC_HI;
                    end
                end
            end
            S_CRC_HI: begin
                if (adv) begin
                    load      = 1'b1;
                    load_byte = r_crc[15:8];
                    n_addr    = r_addr + 32'd1;
                    n_state   = S_CRC_LO;
                end
            end
            S_CRC_LO: begin
                if (adv) begin
                    load      = 1'b1;
                    load_byte = r_crc[7:0];
                    load_done = r_last;
                    n_addr    = r_addr + 32'd1;
                    n_pos     = '0;
                    n_crc     = cpbf_pkg::CRC_INIT;
                    n_state   = S_DATA;
                end
            end
            default: n_state = S_DATA;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_DATA;
            r_pos       <= '0;
            r_crc       <= cpbf_pkg::CRC_INIT;
            r_addr      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_addr  <= n_addr;
            r_last  <= n_last;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= load_byte;
            r_out_addr <= load_addr;
            r_out_done <= load_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_flash_byte = r_out_byte;
    assign o_flash_addr = r_out_addr;
    assign o_write_done = r_out_done;

    `CPBF_ASSERT_NOW(a_pad_after_data, (r_state == S_PAD), (r_pos != '0),
        "pad with no data byte")
    `CPBF_ASSERT_NEXT(a_record_restart, (r_state == S_CRC_LO && adv),
        (r_state == S_DATA && r_pos == '0 && r_crc == cpbf_pkg::CRC_INIT),
        "record state not reset after crc")
    `CPBF_ASSERT_NOW(a_pop_needs_item, o_pop, (!i_q_flags.empty && adv),
        "pop from empty queue or into busy output")

endmodule

// ----- sv/crc_protected_block_framer_top.sv -----
// crc-protected block framer: takes the data bytes of one flash write (start_block
// sampled on the first byte, last_byte on the final one) and turns them into
// 34-byte flash records of 32 data bytes and a crc-16 (poly 0x8005, init 0xffff,
// msb first, high byte first); a short final block is padded with 0xff, and the
// pads count in the crc. every record byte leaves with its address
// flash_base + start_block*34 + record offset + position, modulo 2^32, and
// write_done marks the crc low byte of the write's last record. flash_base is
// written with i_cfg_we and takes effect at the next write. data bytes, pad bytes
// and the two crc bytes are all issued by the single byte sequencer in the back
// end; while it issues pad and crc bytes, the input stalls once the two-entry
// queue is full.
module crc_protected_block_framer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [25:0] i_start_block,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_flash_byte,
    output logic [31:0] o_flash_addr,
    output logic        o_write_done
);

    // partition base register
    logic [31:0] r_flash_base;

    // front to queue to back
    logic                push;
    logic                pop;
    cpbf_pkg::t_item     front_item;
    cpbf_pkg::t_item     head_item;
    cpbf_pkg::t_q_flags  q_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_base <= '0;
        end else if (i_cfg_we) begin
            r_flash_base <= i_cfg_data;
        end
    end

    // classifies each transaction: first byte of a write and its record offset
    cpbf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_start_block (i_start_block),
        .i_q_flags     (q_flags),
        .o_push        (push),
        .o_item        (front_item)
    );

    // decouples input acceptance from the padding and crc bursts
    cpbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_flags (q_flags)
    );

    // emits data, pad and crc bytes with running address
    cpbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_flash_base (r_flash_base),
        .i_item       (head_item),
        .i_q_flags    (q_flags),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_flash_byte (o_flash_byte),
        .o_flash_addr (o_flash_addr),
        .o_write_done (o_write_done)
    );

endmodule
